### rtl/qmul_pkg.sv
// ============================================================================
// qmul_pkg
// Shared widths, types and term tables for the quaternion multiplier.
// ============================================================================
package qmul_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // Full-precision product, one pair sum, and the final rounded sum.
  localparam int PROD_W = 2 * COMP_WIDTH;
  localparam int PSUM_W = PROD_W + 1;
  localparam int SUM_W  = ((PROD_W > FRAC_BITS) ? PROD_W : FRAC_BITS) + 3;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [PSUM_W-1:0]     psum_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // Component indexes (x, y, z vector part, w scalar part).
  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  // [output][term]: which a and b component each product term uses.
  localparam logic [3:0][3:0][1:0] A_SEL = {
    IDX_Z, IDX_Y, IDX_X, IDX_W,   // w
    IDX_Y, IDX_X, IDX_W, IDX_Z,   // z
    IDX_X, IDX_Z, IDX_W, IDX_Y,   // y
    IDX_Z, IDX_Y, IDX_W, IDX_X    // x
  };
  localparam logic [3:0][3:0][1:0] B_SEL = {
    IDX_Z, IDX_Y, IDX_X, IDX_W,   // w
    IDX_X, IDX_Y, IDX_Z, IDX_W,   // z
    IDX_Z, IDX_X, IDX_Y, IDX_W,   // y
    IDX_Y, IDX_Z, IDX_X, IDX_W    // x
  };
  // [output][term]: term enters the sum negated.
  localparam logic [3:0][3:0] TERM_NEG = {4'b1110, 4'b1000, 4'b1000, 4'b1000};

  // Rounding constant (one half LSB) and saturation bounds.
  localparam sum_t RND_HALF = sum_t'(64'sd1 <<< (FRAC_BITS - 1));
  localparam sum_t SAT_MAX  = sum_t'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
  localparam sum_t SAT_MIN  = sum_t'(-(64'sd1 <<< (COMP_WIDTH - 1)));
  localparam comp_t OUT_MAX = comp_t'(SAT_MAX);
  localparam comp_t OUT_MIN = comp_t'(SAT_MIN);

  // Load enables for the two adder stages.
  typedef struct packed {
    logic ld_pair;
    logic ld_total;
  } sum_ld_t;

endpackage

### rtl/qmul_mult.sv
// ============================================================================
// qmul_mult
// Product stage: sixteen signed multiplies, registered.
// ============================================================================
module qmul_mult (
  input  logic              clk,
  input  logic              ld,
  input  qmul_pkg::comp_t   a [4],
  input  qmul_pkg::comp_t   b [4],
  output qmul_pkg::prod_t   prod_r [4][4]
);

  qmul_pkg::prod_t prod_nxt [4][4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[k][j] = qmul_pkg::prod_t'(a[qmul_pkg::A_SEL[k][j]])
                       * qmul_pkg::prod_t'(b[qmul_pkg::B_SEL[k][j]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### rtl/qmul_sum.sv
// ============================================================================
// qmul_sum
// Two-stage adder tree: signed pair sums, then total plus rounding half.
// ============================================================================
module qmul_sum (
  input  logic              clk,
  input  qmul_pkg::sum_ld_t ld,
  input  qmul_pkg::prod_t   prod [4][4],
  output qmul_pkg::sum_t    total_r [4]
);

  qmul_pkg::psum_t term   [4][4];
  qmul_pkg::psum_t lo_nxt [4];
  qmul_pkg::psum_t hi_nxt [4];
  qmul_pkg::psum_t lo_r   [4];
  qmul_pkg::psum_t hi_r   [4];
  qmul_pkg::sum_t  total_nxt [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        term[k][j] = qmul_pkg::TERM_NEG[k][j] ? -qmul_pkg::psum_t'(prod[k][j])
                                              :  qmul_pkg::psum_t'(prod[k][j]);
      end
      lo_nxt[k] = term[k][0] + term[k][1];
      hi_nxt[k] = term[k][2] + term[k][3];
      total_nxt[k] = qmul_pkg::sum_t'(lo_r[k]) + qmul_pkg::sum_t'(hi_r[k])
                   + qmul_pkg::RND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_pair) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (ld.ld_total) begin
      total_r <= total_nxt;
    end
  end

endmodule

### rtl/qmul_rsat.sv
// ============================================================================
// qmul_rsat
// Output stage: drop fraction bits, saturate, collect overflow.
// ============================================================================
module qmul_rsat (
  input  logic             clk,
  input  logic             ld,
  input  qmul_pkg::sum_t   total [4],
  output qmul_pkg::comp_t  res_r [4],
  output logic             ovf_r
);

  qmul_pkg::sum_t  shifted [4];
  qmul_pkg::comp_t res_nxt [4];
  logic [3:0]      sat;
  logic            ovf_nxt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      shifted[k] = total[k] >>> qmul_pkg::FRAC_BITS;
      if (shifted[k] > qmul_pkg::SAT_MAX) begin
        res_nxt[k] = qmul_pkg::OUT_MAX;
        sat[k]     = 1'b1;
      end else if (shifted[k] < qmul_pkg::SAT_MIN) begin
        res_nxt[k] = qmul_pkg::OUT_MIN;
        sat[k]     = 1'b1;
      end else begin
        res_nxt[k] = shifted[k][qmul_pkg::COMP_WIDTH-1:0];
        sat[k]     = 1'b0;
      end
    end
    ovf_nxt = |sat;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

### rtl/quaternion_multiply.sv
// ============================================================================
// quaternion_multiply
// Pipelined Hamilton product of two Q1.14 quaternions with rounding and
// saturation.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries quaternions a and b as eight
//   signed components. Output channel (out_valid/out_ready) returns the
//   product x, y, z, w plus out_overflow, set when any component saturated.
//   Each output is the exact sum of four products, rounded half up and
//   clamped to the signed component range.
//   Pipeline: four register stages (product, pair sum, total,
//   round/saturate); out_valid is the valid of the round/saturate stage.
//   Throughput: one transfer per cycle while out_ready is high; each stage
//   loads whenever it is empty or the stage after it moves, so bubbles are
//   squeezed out.
//   Stall: with out_ready low the output holds and upstream stages keep
//   filling; in_ready drops only once all four stages hold an item. No
//   item is dropped or repeated.
//   Reset (rst_n low, synchronous) empties the pipeline; data registers are
//   not cleared. No state is kept between items.
// ============================================================================
module quaternion_multiply (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [qmul_pkg::COMP_WIDTH-1:0] in_a_x,
  input  logic signed [qmul_pkg::COMP_WIDTH-1:0] in_a_y,
  input  logic signed [qmul_pkg::COMP_WIDTH-1:0] in_a_z,
  input  logic signed [qmul_pkg::COMP_WIDTH-1:0] in_a_w,
  input  logic signed [qmul_pkg::COMP_WIDTH-1:0] in_b_x,
  input  logic signed [qmul_pkg::COMP_WIDTH-1:0] in_b_y,
  input  logic signed [qmul_pkg::COMP_WIDTH-1:0] in_b_z,
  input  logic signed [qmul_pkg::COMP_WIDTH-1:0] in_b_w,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [qmul_pkg::COMP_WIDTH-1:0] out_x,
  output logic signed [qmul_pkg::COMP_WIDTH-1:0] out_y,
  output logic signed [qmul_pkg::COMP_WIDTH-1:0] out_z,
  output logic signed [qmul_pkg::COMP_WIDTH-1:0] out_w,
  output logic                    out_overflow
);

  qmul_pkg::comp_t   a_in [4];
  qmul_pkg::comp_t   b_in [4];
  qmul_pkg::prod_t   prod [4][4];
  qmul_pkg::sum_t    total [4];
  qmul_pkg::comp_t   res [4];
  qmul_pkg::sum_ld_t sum_ld;

  // Stage valids: 0 products, 1 pair sums, 2 totals, 3 output register.
  logic [3:0] valid_r;
  logic [3:0] valid_nxt;
  logic [3:0] move;   // stage may take a new item this cycle
  logic [3:0] feed;   // valid arriving at each stage

  assign a_in[0] = in_a_x;
  assign a_in[1] = in_a_y;
  assign a_in[2] = in_a_z;
  assign a_in[3] = in_a_w;
  assign b_in[0] = in_b_x;
  assign b_in[1] = in_b_y;
  assign b_in[2] = in_b_z;
  assign b_in[3] = in_b_w;

  // Backpressure ripples from the output; an empty stage always accepts.
  always_comb begin
    move[3] = !valid_r[3] || out_ready;
    for (int i = 2; i >= 0; i--) begin
      move[i] = !valid_r[i] || move[i+1];
    end
    feed = {valid_r[2:0], in_valid};
    for (int i = 0; i < 4; i++) begin
      valid_nxt[i] = move[i] ? feed[i] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready = move[0];

  assign sum_ld.ld_pair  = move[1] && feed[1];
  assign sum_ld.ld_total = move[2] && feed[2];

  qmul_mult u_mult (
    .clk    (clk),
    .ld     (move[0] && feed[0]),
    .a      (a_in),
    .b      (b_in),
    .prod_r (prod)
  );

  qmul_sum u_sum (
    .clk     (clk),
    .ld      (sum_ld),
    .prod    (prod),
    .total_r (total)
  );

  qmul_rsat u_rsat (
    .clk   (clk),
    .ld    (move[3] && feed[3]),
    .total (total),
    .res_r (res),
    .ovf_r (out_overflow)
  );

  assign out_valid = valid_r[3];
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign out_w     = res[3];

  // Overflow flag only with a clamped component.
  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      (out_x == qmul_pkg::OUT_MAX || out_x == qmul_pkg::OUT_MIN ||
       out_y == qmul_pkg::OUT_MAX || out_y == qmul_pkg::OUT_MIN ||
       out_z == qmul_pkg::OUT_MAX || out_z == qmul_pkg::OUT_MIN ||
       out_w == qmul_pkg::OUT_MAX || out_w == qmul_pkg::OUT_MIN))
    else $error("overflow set without a saturated component");

  // An input transfer always lands in the product stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r[0])
    else $error("accepted item missing from product stage");

  // Input is refused only when every stage is full and the output stalls.
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (valid_r == 4'hF) && !out_ready)
    else $error("in_ready low with room in the pipeline");

  // A stalled stage keeps its item.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[2] && !move[2] |=> valid_r[2] && valid_r[3])
    else $error("stalled item lost in total stage");

endmodule
